// ===== rtl/asd_pkg.sv =====
`default_nettype none

package asd_pkg;

   // Field widths of the sample, the result and the registers
   localparam int AXIS_W   = 16;
   localparam int TIME_W   = 32;
   localparam int COUNT_W  = 32;
   localparam int ONE_G_W  = 13;
   localparam int THR_W    = 16;
   localparam int IVL_W    = 16;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 2;

   // Packed widths on the stream ports
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 40;

   // Sum of squares, root and magnitude
   localparam int SQ_W       = 32;
   localparam int ROOT_W     = SQ_W / 2;
   localparam int REM_W      = ROOT_W + 1;
   localparam int MAG_W      = 18;
   localparam int ROOT_STEPS = ROOT_W;
   localparam int CNT_W      = $clog2(ROOT_STEPS);
   localparam int AXIS_SEL_W = 2;

   // Default window length
   localparam int WINDOW_DEF = 5;

   // Register reset values
   localparam logic [ONE_G_W-1:0] ONE_G_RST = ONE_G_W'(256);
   localparam logic [THR_W-1:0]   RISE_RST  = THR_W'(51);
   localparam logic [IVL_W-1:0]   MIN_IVL_RST = IVL_W'(300);

   // Register indexes on the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ONE_G   = 2'd0,
      CSR_RISE    = 2'd1,
      CSR_MIN_IVL = 2'd2
   } asd_csr_type;

   // Axis selectors for the shared multiplier
   typedef enum logic [AXIS_SEL_W-1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2,
      AXIS_NONE = 2'd3
   } asd_axis_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic         load;
      logic         mul_en;
      logic         acc_en;
      asd_axis_type axis_sel;
      logic         root_step;
      logic         commit;
   } asd_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/asd_ctrl.sv =====
`default_nettype none

module asd_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output asd_pkg::asd_cmd_type cmd
);
   import asd_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SQUARE = 4'b0010,
      ST_ROOT   = 4'b0100,
      ST_UPDATE = 4'b1000
   } asd_state_type;

   localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(3);
   localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_STEPS - 1);

   asd_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;
   logic             accept;

   // The result register is free once empty or being taken this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // Sequence one sample: squares, root, then window update
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.axis_sel = AXIS_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               cmd.load = 1'b1;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.axis_sel = asd_axis_type'(cnt_ff[AXIS_SEL_W-1:0]);
            cmd.mul_en   = (cnt_ff != SQ_LAST);
            cmd.acc_en   = (cnt_ff != '0);
            if (cnt_ff == SQ_LAST) begin
               cnt_in   = '0;
               state_in = ST_ROOT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == ROOT_LAST) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result valid until the transaction completes
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("commit while result register occupied");

   a_accept_square: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SQUARE) && (cnt_ff == '0))
      else $error("accepted sample did not start squaring");

   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("commit did not raise result valid");

   a_square_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQUARE) |-> (cnt_ff <= SQ_LAST))
      else $error("square counter out of range");

endmodule

`default_nettype wire

// ===== rtl/asd_datapath.sv =====
`default_nettype none

module asd_datapath #(
   parameter int WINDOW = asd_pkg::WINDOW_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  asd_pkg::asd_cmd_type               cmd,
   input  wire [asd_pkg::REQ_DATA_W-1:0]      req_data,
   input  wire                                csr_write,
   input  wire [asd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire [asd_pkg::CSR_W-1:0]           csr_data,
   output logic                               step_seen,
   output logic [asd_pkg::COUNT_W-1:0]        step_total
);
   import asd_pkg::*;

   localparam int SLOT_W = $clog2(WINDOW);
   localparam int SUM_W  = MAG_W + $clog2(WINDOW);
   localparam int LVL_W  = THR_W + $clog2(WINDOW);
   localparam int CMP_W  = SUM_W + 1;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

   // Configuration registers
   logic [ONE_G_W-1:0] one_g_ff;
   logic [THR_W-1:0]   rise_ff;
   logic [IVL_W-1:0]   min_ivl_ff;

   // Captured sample
   logic signed [AXIS_W-1:0] ax_ff, ay_ff, az_ff;
   logic [TIME_W-1:0]        time_ff;

   // Squares and root
   logic signed [AXIS_W-1:0]   axis_val;
   logic signed [2*AXIS_W-1:0] prod_ff;
   logic [SQ_W-1:0]            acc_ff, acc_in;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic [ROOT_W-1:0]          root_ff, root_in;
   logic [REM_W+1:0]           rem_try, root_try;

   // Window and detector state
   logic signed [MAG_W-1:0] win_ff [WINDOW];
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [SLOT_W-1:0]       slot_ff;
   logic                    armed_ff;
   logic [TIME_W-1:0]       last_ff;
   logic [COUNT_W-1:0]      steps_ff;
   logic                    seen_ff;

   logic signed [MAG_W-1:0] mag;
   logic [LVL_W-1:0]        level;
   logic signed [CMP_W-1:0] sum_c, lvl_c;
   logic [TIME_W-1:0]       elapsed;
   logic                    arm_hit, disarm_hit, count_hit;

   // Write the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         one_g_ff   <= ONE_G_RST;
         rise_ff    <= RISE_RST;
         min_ivl_ff <= MIN_IVL_RST;
      end else if (csr_write) begin
         unique case (asd_csr_type'(csr_index))
            CSR_ONE_G:   one_g_ff   <= csr_data[ONE_G_W-1:0];
            CSR_RISE:    rise_ff    <= csr_data[THR_W-1:0];
            CSR_MIN_IVL: min_ivl_ff <= csr_data[IVL_W-1:0];
            default: ;
         endcase
      end
   end

   // Capture the sample on acceptance
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ax_ff   <= $signed(req_data[AXIS_W-1:0]);
         ay_ff   <= $signed(req_data[2*AXIS_W-1:AXIS_W]);
         az_ff   <= $signed(req_data[3*AXIS_W-1:2*AXIS_W]);
         time_ff <= req_data[3*AXIS_W+TIME_W-1:3*AXIS_W];
      end
   end

   // Select one axis for the shared multiplier
   always_comb begin
      case (cmd.axis_sel)
         AXIS_X:  axis_val = ax_ff;
         AXIS_Y:  axis_val = ay_ff;
         AXIS_Z:  axis_val = az_ff;
         default: axis_val = '0;
      endcase
   end

   // One root bit per step, from a bit pair of the sum: trial subtract of 4*root+1
   assign rem_try  = {rem_ff, acc_ff[SQ_W-1:SQ_W-2]};
   assign root_try = {1'b0, root_ff, 2'b01};

   always_comb begin
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (cmd.load) begin
         acc_in  = '0;
         rem_in  = '0;
         root_in = '0;
      end else if (cmd.acc_en) begin
         acc_in = acc_ff + SQ_W'(unsigned'(prod_ff));
      end else if (cmd.root_step) begin
         acc_in = {acc_ff[SQ_W-3:0], 2'b00};
         if (rem_try >= root_try) begin
            rem_in  = REM_W'(rem_try - root_try);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(rem_try);
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= axis_val * axis_val;
      end
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   // Magnitude less one g, then slide the window sum
   assign mag = $signed({{(MAG_W-ROOT_W){1'b0}}, root_ff})
              - $signed({{(MAG_W-ONE_G_W){1'b0}}, one_g_ff});
   assign sum_in = sum_ff - SUM_W'(win_ff[slot_ff]) + SUM_W'(mag);

   // Compare against the threshold scaled by the window length
   assign level   = LVL_W'(rise_ff) * LVL_W'(WINDOW);
   assign sum_c   = CMP_W'(sum_in);
   assign lvl_c   = $signed(CMP_W'(level));
   assign elapsed = time_ff - last_ff;

   assign arm_hit    = (sum_c > lvl_c) && !armed_ff;
   assign disarm_hit = !arm_hit && ((sum_c <<< 1) < lvl_c) && armed_ff;
   assign count_hit  = disarm_hit && (elapsed > TIME_W'(min_ivl_ff));

   // Commit the window and detector state with the result
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            win_ff[i] <= '0;
         end
         sum_ff   <= '0;
         slot_ff  <= '0;
         armed_ff <= 1'b0;
         last_ff  <= '0;
         steps_ff <= '0;
         seen_ff  <= 1'b0;
      end else if (cmd.commit) begin
         win_ff[slot_ff] <= mag;
         sum_ff          <= sum_in;
         slot_ff         <= (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
         seen_ff         <= count_hit;
         if (arm_hit) begin
            armed_ff <= 1'b1;
         end else if (disarm_hit) begin
            armed_ff <= 1'b0;
         end
         if (count_hit) begin
            steps_ff <= steps_ff + 1'b1;
            last_ff  <= time_ff;
         end
      end
   end

   assign step_seen  = seen_ff;
   assign step_total = steps_ff;

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_LAST)
      else $error("window slot beyond window length");

   a_step_once: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && count_hit |=> (steps_ff == $past(steps_ff) + 1'b1) && !armed_ff)
      else $error("counted step did not advance count and disarm");

   a_steps_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.commit |=> $stable(steps_ff) && $stable(armed_ff))
      else $error("detector state changed outside a commit");

endmodule

`default_nettype wire

// ===== rtl/accel_step_detector_unit.sv =====
// A result is registered after the square, root and update states run.
// A new sample is taken only in idle, once the previous one has made its three
// passes through the shared 16x16 multiplier and 16 bit-serial square root steps.
// A sample is accepted while an earlier result still waits on rsp_tready.
// Reset (synchronous, active high) clears the window, sum, arming and count,
// and loads the register defaults; no clearing pass is needed.
`default_nettype none

module accel_step_detector_unit #(
   parameter int WINDOW = asd_pkg::WINDOW_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   // req_tdata: accel_x[15:0], accel_y[31:16], accel_z[47:32], time_ms[79:48]
   input  wire                            req_tvalid,
   output logic                           req_tready,
   input  wire [asd_pkg::REQ_DATA_W-1:0]  req_tdata,
   // rsp_tdata: step_seen[0], step_total[32:1], zero fill[39:33]
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   output logic [asd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire                            csr_valid,
   output logic                           csr_ready,
   input  wire [asd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [asd_pkg::CSR_W-1:0]       csr_data
);
   import asd_pkg::*;

   asd_cmd_type        cmd;
   logic               step_seen;
   logic [COUNT_W-1:0] step_total;

   // Take register writes whenever out of reset
   assign csr_ready = !reset;

   asd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   asd_datapath #(
      .WINDOW (WINDOW)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_tdata),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .step_seen  (step_seen),
      .step_total (step_total)
   );

   // Pack the result transaction
   assign rsp_tdata = {{(RSP_DATA_W-COUNT_W-1){1'b0}}, step_total, step_seen};

endmodule

`default_nettype wire
